[rtl/core/tta_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tap tempo averager package
// Shared widths, register indexes, control word layout and the sequencer
// program of the tap tempo averager.
// ----------------------------------------------------------------------------
package tta_pkg;

    // Serial divider geometry: a 24-bit quotient, two bits retired per step.
    localparam int QUO_W     = 24;
    localparam int DIV_W     = 16;
    localparam int REM_W     = 16;
    localparam int DIV_STEPS = QUO_W / 2;
    localparam int CNT_W     = 4;

    // Milliseconds per minute in Q.8: divided by a gap in milliseconds it gives BPM in Q.8.
    localparam logic [QUO_W-1:0] TEMPO_NUM = 24'd15360000;

    // Configuration registers.
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TEMPO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMPO = 2'd2;

    localparam logic [15:0] TIMEOUT_RESET   = 16'd2000;
    localparam logic [16:0] MIN_TEMPO_RESET = 17'd5120;
    localparam logic [16:0] MAX_TEMPO_RESET = 17'd76800;

    // Program counter and step addresses.
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_WAIT      = 3'd0;
    localparam logic [STEP_W-1:0] STEP_CHECK     = 3'd1;
    localparam logic [STEP_W-1:0] STEP_DIV_TEMPO = 3'd2;
    localparam logic [STEP_W-1:0] STEP_PUSH      = 3'd3;
    localparam logic [STEP_W-1:0] STEP_LOAD_AVG  = 3'd4;
    localparam logic [STEP_W-1:0] STEP_DIV_AVG   = 3'd5;
    localparam logic [STEP_W-1:0] STEP_CLAMP     = 3'd6;
    localparam logic [STEP_W-1:0] STEP_EMIT      = 3'd7;

    typedef enum logic [2:0] {
        OP_CAPTURE,
        OP_CHECK,
        OP_DIV,
        OP_PUSH,
        OP_LOAD_AVG,
        OP_CLAMP,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_NO_FIRE,
        COND_REJECT,
        COND_DIV_RUN,
        COND_FEW,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        logic              accept;
        op_t               op;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ctrl_word_t;

    // The program. When the condition holds the counter loads the target,
    // otherwise it advances; the last step wraps back to the first.
    function automatic ctrl_word_t ucode_fetch(logic [STEP_W-1:0] step);
        ctrl_word_t w;
        w = '{accept: 1'b0, op: OP_CAPTURE, cond: COND_NEXT, target: STEP_WAIT};
        unique case (step)
            STEP_WAIT:      w = '{1'b1, OP_CAPTURE,  COND_NO_FIRE,  STEP_WAIT};
            STEP_CHECK:     w = '{1'b0, OP_CHECK,    COND_REJECT,   STEP_EMIT};
            STEP_DIV_TEMPO: w = '{1'b0, OP_DIV,      COND_DIV_RUN,  STEP_DIV_TEMPO};
            STEP_PUSH:      w = '{1'b0, OP_PUSH,     COND_NEXT,     STEP_WAIT};
            STEP_LOAD_AVG:  w = '{1'b0, OP_LOAD_AVG, COND_FEW,      STEP_EMIT};
            STEP_DIV_AVG:   w = '{1'b0, OP_DIV,      COND_DIV_RUN,  STEP_DIV_AVG};
            STEP_CLAMP:     w = '{1'b0, OP_CLAMP,    COND_NEXT,     STEP_WAIT};
            STEP_EMIT:      w = '{1'b0, OP_EMIT,     COND_OUT_BUSY, STEP_EMIT};
            default:        w = '{1'b1, OP_CAPTURE,  COND_NO_FIRE,  STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

[rtl/core/tap_tempo_averager.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tap tempo averager
// Turns tap times into a moving average tempo in Q.8 BPM, clamped to a
// configurable range, under control of a small microcoded sequencer.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake            Word
// tap in    input      in_valid / in_stall  tap_time_ms
// tempo out output     out_valid / out_stall tempo_q8, tempo_valid, history_count
// config    input      cfg_we               cfg_index, cfg_data
//
// A kept tap goes from the check step through the tempo division, push,
// average load, average division and clamp steps to the emit step; with
// fewer than two tempos held it skips from the average load to emit, and a
// cleared history jumps from check to emit. The shared serial divider
// retires two quotient bits per cycle, once for the tap tempo, once for the average.
// Reset clears the sequencer, the history bookkeeping and the output register
// and loads the register defaults; the history entries themselves are left
// alone. The next tap is taken while a result waits in the output register;
// the sequencer holds at its emit step only if that register is still full.
//
// The sequencer is a program counter over an eight-step control store. Each
// control word names an operation for the datapath, a condition and a jump
// target: when the condition holds the counter loads the target, else it
// steps forward, and the emit step wraps back to the wait step.

module tap_tempo_averager #(
    parameter int HISTORY_DEPTH = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [31:0]                    tap_time_ms,

    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [16:0]                         tempo_q8,
    output logic                                tempo_valid,
    output logic [3:0]                          history_count,

    input  wire logic                           cfg_we,
    input  wire logic [tta_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tta_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tta_pkg::*;

    // The fill count must hold the depth itself; the sum of a full history
    // of 24-bit tempos needs that many bits more.
    localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
    localparam int IDX_W  = $clog2(HISTORY_DEPTH);
    localparam int SLOT_W = FILL_W + 1;
    localparam int SUM_W  = QUO_W + FILL_W;

    // Configuration registers.
    logic [15:0] timeout_reg;
    logic [16:0] min_tempo_reg;
    logic [16:0] max_tempo_reg;

    // Sequencer.
    logic [STEP_W-1:0] pc_reg, pc_next;
    ctrl_word_t        ctrl;
    logic              cond_true;

    // Tap bookkeeping.
    logic [31:0] last_tap_reg, last_tap_next;
    logic        have_last_reg, have_last_next;
    logic        first_reg, first_next;
    logic [31:0] interval_reg, interval_next;

    // History.
    logic [QUO_W-1:0]  hist_mem [HISTORY_DEPTH];
    logic              hist_we;
    logic [IDX_W-1:0]  wr_slot;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [IDX_W-1:0]  oldest_reg, oldest_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [SLOT_W-1:0] slot_sum;
    logic [SLOT_W-1:0] slot_wrap;
    logic              hist_full;

    // Shared serial divider: the dividend shifts out of the top of the
    // quotient register while the quotient bits shift in at the bottom.
    logic [DIV_W-1:0] divisor_reg, divisor_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [REM_W:0]   trial1, trial2;
    logic             take1, take2;
    logic [REM_W-1:0] rem_step1, rem_step2;
    logic [QUO_W-1:0] quo_step1, quo_step2;

    // Result being built and the output register.
    logic [16:0]       res_tempo_reg, res_tempo_next;
    logic              res_valid_reg, res_valid_next;
    logic              out_valid_reg, out_valid_next;
    logic [16:0]       out_tempo_reg, out_tempo_next;
    logic              out_tvalid_reg, out_tvalid_next;
    logic [FILL_W-1:0] out_fill_reg, out_fill_next;
    logic [FILL_W+3:0] out_fill_ext;

    // Helpers.
    logic             in_fire;
    logic             out_busy;
    logic             reject;
    logic             few;
    logic [DIV_W-1:0] tempo_divisor;
    logic [QUO_W-1:0] clamp_lo;
    logic [QUO_W-1:0] clamp_hi;

    assign ctrl     = ucode_fetch(pc_reg);
    assign in_stall = !ctrl.accept;
    assign in_fire  = in_valid && ctrl.accept;
    assign out_busy = out_valid_reg && out_stall;

    // A tap is kept only if there was an earlier one and the gap is short.
    assign reject = first_reg || (interval_reg >= {16'd0, timeout_reg});
    assign few    = fill_reg < FILL_W'(2);

    // Gaps that pass the timeout check fit in 16 bits; a zero gap counts
    // as one millisecond.
    assign tempo_divisor = (interval_reg[15:0] == 16'd0) ? 16'd1 : interval_reg[15:0];

    // Two restoring division steps per cycle.
    always_comb
    begin
        trial1    = {rem_reg, quo_reg[QUO_W-1]};
        take1     = trial1 >= {1'b0, divisor_reg};
        rem_step1 = take1 ? REM_W'(trial1 - {1'b0, divisor_reg}) : REM_W'(trial1);
        quo_step1 = {quo_reg[QUO_W-2:0], take1};
        trial2    = {rem_step1, quo_step1[QUO_W-1]};
        take2     = trial2 >= {1'b0, divisor_reg};
        rem_step2 = take2 ? REM_W'(trial2 - {1'b0, divisor_reg}) : REM_W'(trial2);
        quo_step2 = {quo_step1[QUO_W-2:0], take2};
    end

    // Circular history addressing: while filling, the new tempo goes just
    // past the newest entry; once full it overwrites the oldest.
    always_comb
    begin
        slot_sum  = SLOT_W'(oldest_reg) + SLOT_W'(fill_reg);
        slot_wrap = (slot_sum >= SLOT_W'(HISTORY_DEPTH))
                    ? slot_sum - SLOT_W'(HISTORY_DEPTH) : slot_sum;
        hist_full = fill_reg == FILL_W'(HISTORY_DEPTH);
        wr_slot   = hist_full ? oldest_reg : slot_wrap[IDX_W-1:0];
    end

    // Minimum first, then maximum, so crossed limits give the maximum.
    always_comb
    begin
        clamp_lo = (quo_reg < {7'd0, min_tempo_reg}) ? {7'd0, min_tempo_reg} : quo_reg;
        clamp_hi = (clamp_lo > {7'd0, max_tempo_reg}) ? {7'd0, max_tempo_reg} : clamp_lo;
    end

    // Jump condition and next step.
    always_comb
    begin
        unique case (ctrl.cond)
            COND_NEXT:     cond_true = 1'b0;
            COND_NO_FIRE:  cond_true = !in_fire;
            COND_REJECT:   cond_true = reject;
            COND_DIV_RUN:  cond_true = div_cnt_reg != '0;
            COND_FEW:      cond_true = few;
            COND_OUT_BUSY: cond_true = out_busy;
            default:       cond_true = 1'b0;
        endcase
        pc_next = cond_true ? ctrl.target : pc_reg + STEP_W'(1);
    end

    // Datapath, driven by the operation field of the current control word.
    always_comb
    begin
        last_tap_next   = last_tap_reg;
        have_last_next  = have_last_reg;
        first_next      = first_reg;
        interval_next   = interval_reg;
        fill_next       = fill_reg;
        oldest_next     = oldest_reg;
        sum_next        = sum_reg;
        hist_we         = 1'b0;
        divisor_next    = divisor_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        div_cnt_next    = div_cnt_reg;
        res_tempo_next  = res_tempo_reg;
        res_valid_next  = res_valid_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_tempo_next  = out_tempo_reg;
        out_tvalid_next = out_tvalid_reg;
        out_fill_next   = out_fill_reg;

        unique case (ctrl.op)
            OP_CAPTURE:
            begin
                if (in_fire)
                begin
                    interval_next  = tap_time_ms - last_tap_reg;
                    first_next     = !have_last_reg;
                    last_tap_next  = tap_time_ms;
                    have_last_next = 1'b1;
                end
            end
            OP_CHECK:
            begin
                res_tempo_next = '0;
                res_valid_next = 1'b0;
                if (reject)
                begin
                    fill_next   = '0;
                    oldest_next = '0;
                    sum_next    = '0;
                end
                else
                begin
                    divisor_next = tempo_divisor;
                    rem_next     = '0;
                    quo_next     = TEMPO_NUM;
                    div_cnt_next = CNT_W'(DIV_STEPS - 1);
                end
            end
            OP_DIV:
            begin
                rem_next     = rem_step2;
                quo_next     = quo_step2;
                div_cnt_next = div_cnt_reg - CNT_W'(1);
            end
            OP_PUSH:
            begin
                hist_we = 1'b1;
                if (hist_full)
                begin
                    sum_next    = sum_reg - SUM_W'(hist_mem[oldest_reg]) + SUM_W'(quo_reg);
                    oldest_next = (oldest_reg == IDX_W'(HISTORY_DEPTH - 1))
                                  ? '0 : oldest_reg + IDX_W'(1);
                end
                else
                begin
                    sum_next  = sum_reg + SUM_W'(quo_reg);
                    fill_next = fill_reg + FILL_W'(1);
                end
            end
            OP_LOAD_AVG:
            begin
                // The sum is below fill times 2^24, so the quotient fits in
                // 24 bits and the top of the sum seeds the remainder.
                if (!few)
                begin
                    divisor_next = DIV_W'(fill_reg);
                    rem_next     = REM_W'(sum_reg[SUM_W-1:QUO_W]);
                    quo_next     = sum_reg[QUO_W-1:0];
                    div_cnt_next = CNT_W'(DIV_STEPS - 1);
                end
            end
            OP_CLAMP:
            begin
                res_tempo_next = clamp_hi[16:0];
                res_valid_next = 1'b1;
            end
            OP_EMIT:
            begin
                if (!out_busy)
                begin
                    out_valid_next  = 1'b1;
                    out_tempo_next  = res_tempo_reg;
                    out_tvalid_next = res_valid_reg;
                    out_fill_next   = fill_reg;
                end
            end
            default:
            begin
                hist_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= TIMEOUT_RESET;
            min_tempo_reg <= MIN_TEMPO_RESET;
            max_tempo_reg <= MAX_TEMPO_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TIMEOUT:   timeout_reg   <= cfg_data[15:0];
                CFG_MIN_TEMPO: min_tempo_reg <= cfg_data;
                CFG_MAX_TEMPO: max_tempo_reg <= cfg_data;
                default:       timeout_reg   <= timeout_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= STEP_WAIT;
            last_tap_reg  <= '0;
            have_last_reg <= 1'b0;
            first_reg     <= 1'b1;
            fill_reg      <= '0;
            oldest_reg    <= '0;
            sum_reg       <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            last_tap_reg  <= last_tap_next;
            have_last_reg <= have_last_next;
            first_reg     <= first_next;
            fill_reg      <= fill_next;
            oldest_reg    <= oldest_next;
            sum_reg       <= sum_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        interval_reg   <= interval_next;
        divisor_reg    <= divisor_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        res_tempo_reg  <= res_tempo_next;
        res_valid_reg  <= res_valid_next;
        out_tempo_reg  <= out_tempo_next;
        out_tvalid_reg <= out_tvalid_next;
        out_fill_reg   <= out_fill_next;
        if (hist_we)
        begin
            hist_mem[wr_slot] <= quo_reg;
        end
    end

    assign out_fill_ext  = {4'd0, out_fill_reg};
    assign out_valid     = out_valid_reg;
    assign tempo_q8      = out_tempo_reg;
    assign tempo_valid   = out_tvalid_reg;
    assign history_count = out_fill_ext[3:0];

`ifndef ASSERT_OFF
    // An accepted tap always moves the sequencer on to the timeout check.
    a_fire_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> pc_reg == STEP_CHECK)
        else $error("accepted tap did not advance to the check step");

    // The divider remainder stays below the divisor during division.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == STEP_DIV_TEMPO || pc_reg == STEP_DIV_AVG) |-> rem_reg < divisor_reg)
        else $error("divider remainder not below divisor");

    // The history never holds more tempos than it has slots.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(HISTORY_DEPTH))
        else $error("history fill exceeds depth");

    // A valid tempo is only reported with at least two tempos held.
    a_valid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_tvalid_reg) |-> out_fill_reg >= FILL_W'(2))
        else $error("valid tempo reported with fewer than two tempos");
`endif

endmodule
`default_nettype wire
